FILE: design/utf8sv_pkg.sv
// ----------------------------------------------------------------------------
// utf8sv_pkg: shared types and constants for the UTF-8 stream validator
// Holds the running decode state type, the byte and code point limits, and
// the shortest-form floor lookup used by the update logic.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8sv_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CP_W   = 21;

	// Byte classes at a lead position.
	localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
	localparam logic [BYTE_W-1:0] DEL_BYTE   = 8'h7F;
	localparam logic [BYTE_W-1:0] ASCII_END  = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hC2;
	localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hDF;
	localparam logic [BYTE_W-1:0] LEAD3_LO   = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD3_HI   = 8'hEF;
	localparam logic [BYTE_W-1:0] LEAD4_LO   = 8'hF0;
	localparam logic [BYTE_W-1:0] LEAD4_HI   = 8'hF4;

	// Continuation bytes carry this tag in their top two bits.
	localparam logic [1:0] CONT_TAG = 2'b10;

	// Code point limits.
	localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
	localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
	localparam logic [CP_W-1:0] C1_LO      = 21'h000080;
	localparam logic [CP_W-1:0] C1_HI      = 21'h00009F;
	localparam logic [CP_W-1:0] FLOOR_2B   = 21'h000080;
	localparam logic [CP_W-1:0] FLOOR_3B   = 21'h000800;
	localparam logic [CP_W-1:0] FLOOR_4B   = 21'h010000;

	// Shortest-form classes of an open sequence.
	localparam logic [1:0] CLASS_2B = 2'd0;
	localparam logic [1:0] CLASS_3B = 2'd1;
	localparam logic [1:0] CLASS_4B = 2'd2;

	// Continuation bytes still expected after each lead length.
	localparam logic [1:0] LEFT_2B = 2'd1;
	localparam logic [1:0] LEFT_3B = 2'd2;
	localparam logic [1:0] LEFT_4B = 2'd3;

	// Running state of the string being checked.
	typedef struct packed {
		logic [1:0]      bytes_left;
		logic [CP_W-1:0] code_point;
		logic [1:0]      min_class;
		logic            error_seen;
	} dec_state_t;

	// Smallest code point that a sequence of the given class may encode.
	function automatic logic [CP_W-1:0] floor_of(input logic [1:0] cls);
		logic [CP_W-1:0] f;
		unique case (cls)
			CLASS_2B: f = FLOOR_2B;
			CLASS_3B: f = FLOOR_3B;
			default:  f = FLOOR_4B;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

FILE: design/utf8sv_step.sv
// ----------------------------------------------------------------------------
// utf8sv_step: per-byte state update of the UTF-8 stream validator
// Takes the running state and one byte, and gives the next state and the
// verdict that the string would get if this byte were its last.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8sv_step
	import utf8sv_pkg::*;
(
	input  wire dec_state_t        cur,
	input  wire logic [BYTE_W-1:0] byte_in,
	input  wire logic              last,
	output dec_state_t             nxt,
	output logic                   verdict
);

	dec_state_t      upd;
	logic [CP_W-1:0] cp_shift;
	logic [1:0]      left_dec;
	logic            cp_bad;

	// Shift in six payload bits of a continuation byte.
	assign cp_shift = {cur.code_point[CP_W-7:0], byte_in[5:0]};
	assign left_dec = cur.bytes_left - 2'd1;

	// Range checks on a completed code point.
	assign cp_bad = (cp_shift < floor_of(cur.min_class)) || (cp_shift > CP_MAX) ||
		((cp_shift >= SURR_LO) && (cp_shift <= SURR_HI)) ||
		((cp_shift >= C1_LO) && (cp_shift <= C1_HI));

	// Decode step: leads open a sequence, continuations extend and close it.
	always_comb begin
		upd = cur;
		if (!cur.error_seen) begin
			if (cur.bytes_left == 2'd0) begin
				if ((byte_in < CTRL_LIMIT) || (byte_in == DEL_BYTE)) begin
					upd.error_seen = 1'b1;
				end else if (byte_in < ASCII_END) begin
					upd = cur;
				end else if ((byte_in >= LEAD2_LO) && (byte_in <= LEAD2_HI)) begin
					upd.bytes_left = LEFT_2B;
					upd.code_point = CP_W'(byte_in[4:0]);
					upd.min_class  = CLASS_2B;
				end else if ((byte_in >= LEAD3_LO) && (byte_in <= LEAD3_HI)) begin
					upd.bytes_left = LEFT_3B;
					upd.code_point = CP_W'(byte_in[3:0]);
					upd.min_class  = CLASS_3B;
				end else if ((byte_in >= LEAD4_LO) && (byte_in <= LEAD4_HI)) begin
					upd.bytes_left = LEFT_4B;
					upd.code_point = CP_W'(byte_in[2:0]);
					upd.min_class  = CLASS_4B;
				end else begin
					upd.error_seen = 1'b1;
				end
			end else if (byte_in[7:6] != CONT_TAG) begin
				upd.error_seen = 1'b1;
			end else if (left_dec == 2'd0) begin
				upd.bytes_left = 2'd0;
				upd.code_point = '0;
				upd.min_class  = CLASS_2B;
				upd.error_seen = cp_bad;
			end else begin
				upd.bytes_left = left_dec;
				upd.code_point = cp_shift;
			end
		end
	end

	// The verdict needs no error and no open sequence; a final byte clears all.
	assign verdict = !upd.error_seen && (upd.bytes_left == 2'd0);
	assign nxt     = last ? dec_state_t'('0) : upd;

endmodule

`default_nettype wire

FILE: design/utf8_stream_validator.sv
// ----------------------------------------------------------------------------
// utf8_stream_validator: streaming UTF-8 well-formedness checker
// Checks a string one byte per item and gives one verdict item per string,
// on the byte flagged as final.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload               | Item
//  --------+-----------------------+-----------------------+------------------
//  input   | in_valid / in_ready   | byte_value, is_final  | one string byte
//  output  | out_valid / out_ready | valid_res             | one verdict
//
// One byte is taken every cycle, save while a final byte waits on a held verdict;
// the pace is set by the running decode state update from the input register.
// A verdict is loaded into the verdict register as its final byte leaves the input register.
// Reset clears the input register valid, the decode state and the verdict.
// A held verdict stalls only a following final byte; other bytes keep going.
//
`default_nettype none

module utf8_stream_validator
	import utf8sv_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [BYTE_W-1:0] byte_value,
	input  wire logic              is_final,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   valid_res
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              final_s1;
	dec_state_t        state_q;
	dec_state_t        state_nxt;
	logic              verdict;
	logic              out_valid_q;
	logic              valid_res_q;
	logic              adv_s1;

	// A byte leaves the input register unless it is final and the verdict slot is full.
	assign adv_s1   = valid_s1 && (!final_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= byte_value;
			final_s1 <= is_final;
		end
	end

	// Decode update.
	utf8sv_step u_step (
		.cur     (state_q),
		.byte_in (byte_s1),
		.last    (final_s1),
		.nxt     (state_nxt),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Verdict register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			valid_res_q <= 1'b0;
		end else if (adv_s1 && final_s1) begin
			out_valid_q <= 1'b1;
			valid_res_q <= verdict;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = valid_res_q;

	// A final byte leaves the decode state cleared for the next string.
	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && final_s1) |=> (state_q == dec_state_t'('0)))
		else $error("decode state not cleared after final item");

	// With no open sequence, no partial code point or class remains.
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.bytes_left == 2'd0) |-> ((state_q.code_point == '0) &&
		(state_q.min_class == CLASS_2B)))
		else $error("stale code point with no open sequence");

	// A final byte blocked by a held verdict also blocks the input.
	a_final_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && final_s1 && out_valid_q && !out_ready) |-> !in_ready)
		else $error("input taken while final item is stalled");

	// A new verdict is loaded only when the old one is gone or being taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> ($stable(valid_res_q) && out_valid_q))
		else $error("pending verdict overwritten");

endmodule

`default_nettype wire
